@@ rtl/core/first_fit_range_allocator_macros.svh @@
// Assertion macros for the first-fit range allocator.
// Used by the top level only; no other dependencies.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// checked while out of reset
`define FFRA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define FFRA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FFRA_ASSERT(lbl, prop, msg)
`define FFRA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/core/ffra_pkg.sv @@
// Shared types and constants of the first-fit range allocator.
// No dependencies.
package ffra_pkg;

   localparam int MAX_RANGES_DEF = 64;
   localparam int ADDR_BITS_DEF  = 48;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [47:0] POOL_BASE_RST = 48'd4096;
   localparam logic [47:0] POOL_SIZE_RST = 48'd16384;

   localparam logic [CSR_IDX_BITS-1:0] CSR_POOL_BASE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POOL_SIZE = 2'd1;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_OVERLAP = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef enum logic [2:0] {
      FSM_IDLE = 3'b001,
      FSM_RUN  = 3'b010,
      FSM_FIN  = 3'b100
   } fsm_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

@@ rtl/core/ffra_cell.sv @@
// One slot of the free-range ring: holds a [low, high) pair.
// Depends on ffra_pkg.
module ffra_cell #(
   parameter int ADDR_BITS = ffra_pkg::ADDR_BITS_DEF
) (
   input  logic                    clock,
   input  ffra_pkg::cell_ctrl_type ctrl,
   input  logic [ADDR_BITS-1:0]    load_lo,
   input  logic [ADDR_BITS-1:0]    load_hi,
   input  logic [ADDR_BITS-1:0]    shift_lo,
   input  logic [ADDR_BITS-1:0]    shift_hi,
   output logic [ADDR_BITS-1:0]    lo,
   output logic [ADDR_BITS-1:0]    hi
);
   import ffra_pkg::*;

   logic [ADDR_BITS-1:0] lo_ff;
   logic [ADDR_BITS-1:0] hi_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         lo_ff <= load_lo;
         hi_ff <= load_hi;
      end else if (ctrl.shift) begin
         lo_ff <= shift_lo;
         hi_ff <= shift_hi;
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;

endmodule

@@ rtl/core/first_fit_range_allocator.sv @@
// Top level of the first-fit range allocator: ring of range cells plus scan control.
// Depends on ffra_pkg, ffra_cell and first_fit_range_allocator_macros.svh.
//
// A request (start while busy is low) goes through states RUN and FIN: the free table
// sits in a ring of MAX_RANGES cells that turns once per request in RUN, one slot per
// cycle past the head, where the controller edits, drops or inserts a range; then FIN
// settles the status and the response registers show it. The result is on rsp_* for
// exactly one cycle, marked by rsp_valid, and cannot be held off, so capture it then.
// busy stays high until the result beat; a new request may start in the cycle the
// result shows. Register writes are taken only while busy is low and start is low,
// and rebuild the table as one range.
module first_fit_range_allocator #(
   parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF,
   parameter int ADDR_BITS  = ffra_pkg::ADDR_BITS_DEF,
   localparam int TW = $clog2(MAX_RANGES),
   localparam int CW = $clog2(MAX_RANGES + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_operation,
   input  logic [ADDR_BITS-1:0]              req_request_size,
   input  logic [ADDR_BITS-1:0]              req_release_address,
   output logic                              rsp_valid,
   output logic [ADDR_BITS-1:0]              rsp_granted_address,
   output logic [1:0]                        rsp_status,
   output logic [ADDR_BITS-1:0]              rsp_free_total,
   output logic [ADDR_BITS-1:0]              rsp_biggest_free_size,
   output logic [ADDR_BITS-1:0]              rsp_biggest_free_address,
   output logic [CW-1:0]                     rsp_range_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ffra_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [ADDR_BITS-1:0]              csr_wdata
);
   import ffra_pkg::*;

`include "first_fit_range_allocator_macros.svh"

   localparam logic [TW-1:0] T_LAST = TW'(MAX_RANGES - 1);
   localparam logic [CW-1:0] C_FULL = CW'(MAX_RANGES);

   // ---- ring of cells; cell 0 is the head, cell MAX_RANGES-1 takes the tail beat
   logic [ADDR_BITS-1:0] cell_lo [MAX_RANGES];
   logic [ADDR_BITS-1:0] cell_hi [MAX_RANGES];
   logic [ADDR_BITS-1:0] tail_lo, tail_hi;
   logic [ADDR_BITS-1:0] load_lo, load_hi;
   cell_ctrl_type        head_ctrl, body_ctrl;

   fsm_type state_ff, state_in;

   genvar k;
   generate
      for (k = 0; k < MAX_RANGES; k++) begin : g_cell
         if (k == MAX_RANGES - 1) begin : g_tail
            ffra_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
               .clock(clock), .ctrl((k == 0) ? head_ctrl : body_ctrl),
               .load_lo(load_lo), .load_hi(load_hi),
               .shift_lo(tail_lo), .shift_hi(tail_hi),
               .lo(cell_lo[k]), .hi(cell_hi[k]));
         end else begin : g_body
            ffra_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
               .clock(clock), .ctrl((k == 0) ? head_ctrl : body_ctrl),
               .load_lo(load_lo), .load_hi(load_hi),
               .shift_lo(cell_lo[k+1]), .shift_hi(cell_hi[k+1]),
               .lo(cell_lo[k]), .hi(cell_hi[k]));
         end
      end
   endgenerate

   // ---- registers
   logic                 op_ff;
   logic [ADDR_BITS-1:0] size_ff, addr_ff;
   logic [TW-1:0]        t_ff, t_in;
   logic [CW-1:0]        cnt_ff, cnt_new_ff, cnt_new_in;
   logic                 carry_on_ff, carry_on_in, skip_on_ff, skip_on_in;
   logic [ADDR_BITS-1:0] carry_lo_ff, carry_lo_in, carry_hi_ff, carry_hi_in;
   logic                 decided_ff, decided_in;
   logic [1:0]           status_ff, status_in;
   logic [ADDR_BITS-1:0] granted_ff, granted_in;
   logic [ADDR_BITS-1:0] free_ff, free_in, lg_size_ff, lg_size_in, lg_addr_ff, lg_addr_in;
   logic [ADDR_BITS-1:0] base_ff, psize_ff;
   logic                 rsp_valid_ff;
   logic [ADDR_BITS-1:0] rsp_granted_ff, rsp_free_ff, rsp_lg_size_ff, rsp_lg_addr_ff;
   logic [1:0]           rsp_status_ff;
   logic [CW-1:0]        rsp_count_ff;

   // ---- configuration: a write rebuilds the table as the single pool range
   logic                 csr_we;
   logic [ADDR_BITS-1:0] new_base, new_size;

   // held off while a request is offered, so a write never lands with a request beat
   assign csr_ready = (state_ff == FSM_IDLE) && !start;
   assign csr_we    = csr_valid && csr_ready &&
                      ((csr_index == CSR_POOL_BASE) || (csr_index == CSR_POOL_SIZE));
   assign new_base  = (csr_index == CSR_POOL_BASE) ? csr_wdata : base_ff;
   assign new_size  = (csr_index == CSR_POOL_SIZE) ? csr_wdata : psize_ff;

   always_comb begin
      if (reset) begin
         load_lo = ADDR_BITS'(POOL_BASE_RST);
         load_hi = ADDR_BITS'(POOL_BASE_RST) + ADDR_BITS'(POOL_SIZE_RST);
      end else begin
         load_lo = new_base;
         load_hi = new_base + new_size;
      end
   end

   assign head_ctrl.load  = reset || csr_we;
   assign head_ctrl.shift = (state_ff == FSM_RUN);
   assign body_ctrl.load  = 1'b0;
   assign body_ctrl.shift = (state_ff == FSM_RUN);

   // ---- scan: look at the head (and the slot behind it for a double merge)
   logic [ADDR_BITS-1:0] head_lo, head_hi, next_lo, next_hi;
   logic [ADDR_BITS-1:0] head_span, rel_end, out_span;
   logic [ADDR_BITS-1:0] lz_size, lz_addr;
   logic [CW-1:0]        t_ext;
   logic                 accept;

   assign head_lo   = cell_lo[0];
   assign head_hi   = cell_hi[0];
   assign next_lo   = cell_lo[1];
   assign next_hi   = cell_hi[1];
   assign head_span = head_hi - head_lo;
   assign rel_end   = addr_ff + size_ff;
   assign t_ext     = CW'(t_ff);
   assign accept    = start && !busy;

   always_comb begin
      state_in    = state_ff;
      t_in        = t_ff;
      cnt_new_in  = cnt_new_ff;
      carry_on_in = carry_on_ff;
      carry_lo_in = carry_lo_ff;
      carry_hi_in = carry_hi_ff;
      skip_on_in  = skip_on_ff;
      decided_in  = decided_ff;
      status_in   = status_ff;
      granted_in  = granted_ff;
      free_in     = free_ff;
      lg_size_in  = lg_size_ff;
      lg_addr_in  = lg_addr_ff;
      tail_lo     = head_lo;
      tail_hi     = head_hi;
      lz_size     = lg_size_ff;
      lz_addr     = lg_addr_ff;
      out_span    = '0;

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in    = FSM_RUN;
               t_in        = '0;
               cnt_new_in  = cnt_ff;
               carry_on_in = 1'b0;
               skip_on_in  = 1'b0;
               decided_in  = 1'b0;
               status_in   = ST_OK;
               granted_in  = '0;
            end
         end
         FSM_RUN: begin
            t_in = t_ff + 1'b1;
            if (t_ff == T_LAST) begin
               state_in = FSM_FIN;
            end
            if (skip_on_ff) begin
               // a range was dropped: everything behind moves up one slot
               tail_lo = next_lo;
               tail_hi = next_hi;
            end else if (carry_on_ff) begin
               // a range was inserted: ripple the displaced one down to the first free slot
               tail_lo     = carry_lo_ff;
               tail_hi     = carry_hi_ff;
               carry_lo_in = head_lo;
               carry_hi_in = head_hi;
               if (t_ext == cnt_ff) begin
                  carry_on_in = 1'b0;
               end
            end else if (!decided_ff && (t_ext < cnt_ff)) begin
               if (op_ff == OP_ALLOC) begin
                  if (head_span >= size_ff) begin
                     decided_in = 1'b1;
                     granted_in = head_lo;
                     free_in    = free_ff - size_ff;
                     if (head_span == size_ff) begin
                        skip_on_in = 1'b1;
                        cnt_new_in = cnt_ff - 1'b1;
                        tail_lo    = next_lo;
                        tail_hi    = next_hi;
                     end else begin
                        tail_lo = head_lo + size_ff;
                        if (lg_addr_ff == head_lo) begin
                           lg_size_in = (lg_size_ff > size_ff) ? lg_size_ff - size_ff : '0;
                           lg_addr_in = head_lo + size_ff;
                        end
                     end
                  end
               end else begin
                  // lazy check on the visited range
                  if (head_span > lg_size_ff) begin
                     lz_size = head_span;
                     lz_addr = head_lo;
                  end
                  lg_size_in = lz_size;
                  lg_addr_in = lz_addr;
                  if (addr_ff > head_hi) begin
                     // freed range lies further up
                  end else if (rel_end == head_lo) begin
                     decided_in = 1'b1;
                     free_in    = free_ff + size_ff;
                     tail_lo    = addr_ff;
                     out_span   = head_hi - addr_ff;
                     if (out_span > lz_size) begin
                        lg_size_in = out_span;
                        lg_addr_in = addr_ff;
                     end
                  end else if (addr_ff == head_hi) begin
                     decided_in = 1'b1;
                     free_in    = free_ff + size_ff;
                     if (((t_ext + 1'b1) < cnt_ff) && (next_lo == rel_end)) begin
                        // bridges the gap: swallow the next range too
                        tail_hi    = next_hi;
                        skip_on_in = 1'b1;
                        cnt_new_in = cnt_ff - 1'b1;
                     end else begin
                        tail_hi = rel_end;
                     end
                     out_span = tail_hi - head_lo;
                     if (out_span > lz_size) begin
                        lg_size_in = out_span;
                        lg_addr_in = head_lo;
                     end
                  end else if (rel_end < head_lo) begin
                     decided_in = 1'b1;
                     if (cnt_ff >= C_FULL) begin
                        status_in = ST_FULL;
                     end else begin
                        free_in     = free_ff + size_ff;
                        cnt_new_in  = cnt_ff + 1'b1;
                        tail_lo     = addr_ff;
                        tail_hi     = rel_end;
                        carry_on_in = 1'b1;
                        carry_lo_in = head_lo;
                        carry_hi_in = head_hi;
                     end
                  end else begin
                     decided_in = 1'b1;
                     status_in  = ST_OVERLAP;
                  end
               end
            end else if (!decided_ff && (t_ext == cnt_ff) && (op_ff == OP_RELEASE)) begin
               // past the last range (or empty table): append
               decided_in = 1'b1;
               free_in    = free_ff + size_ff;
               cnt_new_in = cnt_ff + 1'b1;
               tail_lo    = addr_ff;
               tail_hi    = rel_end;
            end
         end
         FSM_FIN: begin
            state_in = FSM_IDLE;
            if (!decided_ff) begin
               status_in = (op_ff == OP_ALLOC) ? ST_NOFIT : ST_FULL;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         carry_on_ff  <= 1'b0;
         skip_on_ff   <= 1'b0;
         decided_ff   <= 1'b0;
         base_ff      <= ADDR_BITS'(POOL_BASE_RST);
         psize_ff     <= ADDR_BITS'(POOL_SIZE_RST);
         cnt_ff       <= CW'(1);
         free_ff      <= ADDR_BITS'(POOL_SIZE_RST);
         lg_size_ff   <= ADDR_BITS'(POOL_SIZE_RST);
         lg_addr_ff   <= ADDR_BITS'(POOL_BASE_RST);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == FSM_FIN);
         carry_on_ff  <= carry_on_in;
         skip_on_ff   <= skip_on_in;
         decided_ff   <= decided_in;
         if (csr_we) begin
            base_ff    <= new_base;
            psize_ff   <= new_size;
            cnt_ff     <= CW'(1);
            free_ff    <= new_size;
            lg_size_ff <= new_size;
            lg_addr_ff <= new_base;
         end else begin
            free_ff    <= free_in;
            lg_size_ff <= lg_size_in;
            lg_addr_ff <= lg_addr_in;
            if (state_ff == FSM_FIN) begin
               cnt_ff <= cnt_new_ff;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      cnt_new_ff  <= cnt_new_in;
      carry_lo_ff <= carry_lo_in;
      carry_hi_ff <= carry_hi_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      if (accept) begin
         op_ff   <= req_operation;
         size_ff <= req_request_size;
         addr_ff <= req_release_address;
      end
      if (state_ff == FSM_FIN) begin
         rsp_granted_ff <= granted_ff;
         rsp_status_ff  <= status_in;
         rsp_free_ff    <= free_ff;
         rsp_lg_size_ff <= lg_size_ff;
         rsp_lg_addr_ff <= lg_addr_ff;
         rsp_count_ff   <= cnt_new_ff;
      end
   end

   assign busy                     = (state_ff != FSM_IDLE);
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_granted_address      = rsp_granted_ff;
   assign rsp_status               = rsp_status_ff;
   assign rsp_free_total           = rsp_free_ff;
   assign rsp_biggest_free_size    = rsp_lg_size_ff;
   assign rsp_biggest_free_address = rsp_lg_addr_ff;
   assign rsp_range_count          = rsp_count_ff;

   // ---- checks
   `FFRA_ASSERT(a_rsp_single_beat, rsp_valid |=> !rsp_valid, "result beat longer than one cycle")
   `FFRA_ASSERT(a_start_goes_busy, (start && !busy) |=> busy, "accepted request did not go busy")
   `FFRA_ASSERT(a_one_edit_mode, !(carry_on_ff && skip_on_ff), "insert and drop at once")
   `FFRA_ASSERT(a_count_bound, rsp_valid |-> (rsp_range_count <= C_FULL), "range count overflow")

endmodule

@@ verif/first_fit_range_allocator_test.sv @@
// Self-checking testbench for first_fit_range_allocator.
// Needs ffra_pkg and the allocator RTL. A built-in free-table predictor checks every result.
module first_fit_range_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ffra_pkg::*;

   localparam int AW = ADDR_BITS_DEF;
   localparam int NR = MAX_RANGES_DEF;
   // longest run with nothing moving: one request plus the worst sender gap, many times over
   localparam int STALL_LIMIT = 4000;

   typedef logic [AW-1:0] addr_type;

   typedef struct packed {
      addr_type   granted;
      logic [1:0] status;
      addr_type   free_total;
      addr_type   big_size;
      addr_type   big_addr;
      logic [6:0] count;
   } outcome_type;

   typedef struct packed {
      addr_type at;
      addr_type len;
   } block_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_operation = OP_ALLOC;
   addr_type   req_request_size = '0;
   addr_type   req_release_address = '0;
   logic       rsp_valid;
   addr_type   rsp_granted_address;
   logic [1:0] rsp_status;
   addr_type   rsp_free_total;
   addr_type   rsp_biggest_free_size;
   addr_type   rsp_biggest_free_address;
   logic [6:0] rsp_range_count;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_POOL_BASE;
   addr_type   csr_wdata = '0;

   first_fit_range_allocator dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---- free-table predictor -------------------------------------------------------
   addr_type pool_base_q, pool_size_q;
   addr_type tbl_lo [NR];
   addr_type tbl_hi [NR];
   int       tbl_count;
   addr_type free_bytes, big_size_q, big_addr_q;

   outcome_type pending_outcomes[$];   // expected results, oldest first
   block_type   live_blocks[$];        // granted ranges not yet handed back
   int          mismatches = 0;
   bit          gaps_on = 1'b1;

   function automatic void rebuild_table();
      tbl_lo[0]  = pool_base_q;
      tbl_hi[0]  = pool_base_q + pool_size_q;
      tbl_count  = 1;
      free_bytes = pool_size_q;
      big_size_q = pool_size_q;
      big_addr_q = pool_base_q;
   endfunction

   function automatic addr_type span_of(int i);
      return tbl_hi[i] - tbl_lo[i];
   endfunction

   function automatic void drop_range(int i);
      for (int k = i; k + 1 < tbl_count; k++) begin
         tbl_lo[k] = tbl_lo[k+1];
         tbl_hi[k] = tbl_hi[k+1];
      end
      tbl_count--;
   endfunction

   function automatic void insert_range(int i, addr_type lo, addr_type hi);
      for (int k = tbl_count; k > i; k--) begin
         tbl_lo[k] = tbl_lo[k-1];
         tbl_hi[k] = tbl_hi[k-1];
      end
      tbl_lo[i] = lo;
      tbl_hi[i] = hi;
      tbl_count++;
   endfunction

   // lazy biggest-range tracking: only ever grows on a visit
   function automatic void note_biggest(int i);
      if (span_of(i) > big_size_q) begin
         big_size_q = span_of(i);
         big_addr_q = tbl_lo[i];
      end
   endfunction

   function automatic logic [1:0] allocate_range(addr_type len, output addr_type at);
      addr_type s;
      at = '0;
      for (int i = 0; i < tbl_count; i++) begin
         s = span_of(i);
         if (s >= len) begin
            at = tbl_lo[i];
            if (s == len) drop_range(i);   // exact fit: tracked biggest left alone
            else begin
               tbl_lo[i] = at + len;
               if (big_addr_q == at) begin
                  big_size_q = (big_size_q > len) ? big_size_q - len : '0;
                  big_addr_q = tbl_lo[i];
               end
            end
            free_bytes = free_bytes - len;
            return ST_OK;
         end
      end
      return ST_NOFIT;
   endfunction

   function automatic logic [1:0] release_range(addr_type first, addr_type len);
      addr_type last, lo, hi;
      last = first + len;
      for (int i = 0; i < tbl_count; i++) begin
         lo = tbl_lo[i];
         hi = tbl_hi[i];
         note_biggest(i);
         if (first > hi) continue;
         if (last == lo) begin
            tbl_lo[i] = first;
            note_biggest(i);
         end else if (first == hi) begin
            // grow upwards, swallowing the next range when the gap closes
            tbl_hi[i] = last;
            if (i + 1 < tbl_count && tbl_lo[i+1] == last) begin
               tbl_hi[i] = tbl_hi[i+1];
               drop_range(i + 1);
            end
            note_biggest(i);
         end else if (last < lo) begin
            if (tbl_count >= NR) return ST_FULL;
            insert_range(i, first, last);
         end else
            return ST_OVERLAP;
         free_bytes = free_bytes + len;
         return ST_OK;
      end
      // past every range, or the table is empty
      if (tbl_count >= NR) return ST_FULL;
      insert_range(tbl_count, first, last);
      free_bytes = free_bytes + len;
      return ST_OK;
   endfunction

   function automatic outcome_type predict_request(logic op, addr_type len, addr_type where);
      outcome_type o;
      addr_type    at;
      at = '0;
      if (op == OP_ALLOC) o.status = allocate_range(len, at);
      else                o.status = release_range(where, len);
      o.granted    = at;
      o.free_total = free_bytes;
      o.big_size   = big_size_q;
      o.big_addr   = big_addr_q;
      o.count      = 7'(tbl_count);
      return o;
   endfunction

   // ---- request side ----------------------------------------------------------------
   // sends one request beat; start is left high so back-to-back beats need no toggle
   task automatic send_request(logic op, addr_type len, addr_type where);
      outcome_type o;
      block_type   b;
      if (gaps_on && $urandom_range(99) < 14) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start               <= 1'b1;
      req_operation       <= op;
      req_request_size    <= len;
      req_release_address <= where;
      do @(posedge clock); while (busy);
      o = predict_request(op, len, where);
      pending_outcomes.push_back(o);
      if (op == OP_ALLOC && o.status == ST_OK) begin
         b.at  = o.granted;
         b.len = len;
         live_blocks.push_back(b);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register writes only with the block idle; each one rebuilds the table
   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, addr_type value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_POOL_BASE) pool_base_q = value;
      else                      pool_size_q = value;
      rebuild_table();
      live_blocks.delete();
   endtask

   task automatic set_pool(addr_type base, addr_type size);
      write_csr(CSR_POOL_BASE, base);
      write_csr(CSR_POOL_SIZE, size);
   endtask

   function automatic addr_type wide_random();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // ---- result side -----------------------------------------------------------------
   always @(posedge clock) begin
      outcome_type o;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $error("result beat with nothing expected");
            mismatches++;
         end else begin
            o = pending_outcomes.pop_front();
            if (rsp_granted_address !== o.granted) begin
               $error("granted_address: expected %h, got %h", o.granted, rsp_granted_address);
               mismatches++;
            end
            if (rsp_status !== o.status) begin
               $error("status: expected %0d, got %0d", o.status, rsp_status);
               mismatches++;
            end
            if (rsp_free_total !== o.free_total) begin
               $error("free_total: expected %h, got %h", o.free_total, rsp_free_total);
               mismatches++;
            end
            if (rsp_biggest_free_size !== o.big_size) begin
               $error("biggest_free_size: expected %h, got %h", o.big_size,
                      rsp_biggest_free_size);
               mismatches++;
            end
            if (rsp_biggest_free_address !== o.big_addr) begin
               $error("biggest_free_address: expected %h, got %h", o.big_addr,
                      rsp_biggest_free_address);
               mismatches++;
            end
            if (rsp_range_count !== o.count) begin
               $error("range_count: expected %0d, got %0d", o.count, rsp_range_count);
               mismatches++;
            end
         end
      end
   end

   // watchdog: cycles in a row where no beat of any kind moves
   int stall_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---- tests -----------------------------------------------------------------------
   // extremes and every special case, starting from the reset pool
   task automatic test_directed();
      send_request(OP_ALLOC, 48'd1, '0);                 // shrinks the tracked range
      send_request(OP_ALLOC, 48'hFFFF_FFFF_FFFF, '0);    // no fit
      send_request(OP_ALLOC, 48'd16383, '0);             // exact fit: table empties
      send_request(OP_RELEASE, 48'd16, 48'h2000);        // release into an empty table
      send_request(OP_RELEASE, 48'd16, 48'h2008);        // overlap
      send_request(OP_RELEASE, 48'd16, 48'h1FF0);        // merge below
      send_request(OP_RELEASE, 48'd16, 48'h2040);        // new range above
      send_request(OP_RELEASE, 48'd48, 48'h2010);        // merge above, swallows next
      send_request(OP_RELEASE, 48'd8, 48'h1000);         // new range below
      send_request(OP_RELEASE, 48'd8, 48'h1008);         // touches the range below: grows it upwards
      send_request(OP_ALLOC, 48'd8, '0);
      // pool at address zero: a grant of zero is a success
      set_pool('0, 48'h800);
      send_request(OP_ALLOC, 48'd1, '0);
      send_request(OP_RELEASE, 48'd1, '0);
      // top of the address space, range end wraps to zero
      set_pool(48'hFFFF_FFFF_FF00, 48'h100);
      send_request(OP_ALLOC, 48'h80, '0);
      send_request(OP_RELEASE, 48'h80, 48'hFFFF_FFFF_FF00);
      send_request(OP_RELEASE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      // smallest and largest pools
      set_pool(48'h10, 48'd1);
      send_request(OP_ALLOC, 48'd1, '0);
      send_request(OP_ALLOC, 48'd1, '0);
      set_pool('0, 48'hFFFF_FFFF_FFFF);
      send_request(OP_ALLOC, 48'h8000_0000_0000, '0);
      send_request(OP_ALLOC, 48'h7FFF_FFFF_FFFF, '0);
   endtask

   // fragment the pool until a release finds the table full
   task automatic test_table_full();
      set_pool(48'h4000, 48'h1000);
      for (int i = 0; i < 140; i++) send_request(OP_ALLOC, 48'd16, '0);
      for (int i = 0; i < 140; i += 2)
         send_request(OP_RELEASE, 48'd16, 48'h4000 + addr_type'(i * 16));
      // sender holds off until the block has caught up
      drain();
      for (int i = 1; i < 40; i += 2)
         send_request(OP_RELEASE, 48'd16, 48'h4000 + addr_type'(i * 16));
   endtask

   // mostly well-formed alloc/free traffic over a pool, with some noise
   task automatic random_phase(addr_type base, addr_type size, int items, int max_len);
      int        pick;
      block_type b;
      addr_type  off;
      set_pool(base, size);
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_request(logic'($urandom_range(1)), wide_random() >> $urandom_range(47),
                         wide_random());
         end else if (pick < 50 || live_blocks.size() == 0) begin
            send_request(OP_ALLOC, addr_type'($urandom_range(1, max_len)), '0);
         end else begin
            pick = $urandom_range(live_blocks.size() - 1);
            b = live_blocks[pick];
            live_blocks.delete(pick);
            if (b.len > 2 && $urandom_range(3) == 0) begin
               // hand back part of the block only
               off = addr_type'($urandom_range(0, 32'(b.len) - 2));
               send_request(OP_RELEASE, b.len - off, b.at + off);
            end else
               send_request(OP_RELEASE, b.len, b.at);
         end
      end
   endtask

   task automatic test_random();
      random_phase(48'h1000, 48'h4000, 400, 300);
      gaps_on = 1'b0;                                  // a stretch with back-to-back beats
      random_phase('0, 48'h800, 300, 40);
      gaps_on = 1'b1;
      random_phase(48'hFFFF_FFFF_F000, 48'h2000, 350, 200);
      random_phase(wide_random(), 48'h10_0000, 350, 4000);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      pool_base_q = POOL_BASE_RST;
      pool_size_q = POOL_SIZE_RST;
      rebuild_table();
      @(posedge clock);
      test_directed();
      test_table_full();
      test_random();
      drain();
      repeat (80) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

@@ first_fit_range_allocator.f @@
+incdir+rtl/core
rtl/core/ffra_pkg.sv
rtl/core/ffra_cell.sv
rtl/core/first_fit_range_allocator.sv
verif/first_fit_range_allocator_test.sv
